/* hdl/tcw_pkg.sv */
// Shared types and constants for the text console writer.
package tcw_pkg;

   localparam int FUNC_W  = 2;
   localparam int CHAR_W  = 8;
   localparam int INDEX_W = 11;
   localparam int LOC_W   = 11;
   localparam int CELL_W  = 16;
   localparam int ATTR_W  = 8;

   localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

   typedef struct packed {
      logic idle;
      logic exec;
      logic read;
      logic copy;
      logic blank;
      logic clear;
      logic done;
   } tcw_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic is_put;
      logic is_clear;
      logic is_read;
      logic scroll_needed;
      logic copy_last;
      logic cell_last;
      logic rsp_free;
   } tcw_status_type;

endpackage

/* hdl/tcw_ifs.sv */
// Request and response channel interfaces of the text console writer.
interface tcw_req_if;
   import tcw_pkg::*;

   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [CHAR_W-1:0]  char_code;
   logic [INDEX_W-1:0] cell_index;

   modport source (output valid, output func, output char_code, output cell_index,
                   input ready);
   modport sink   (input valid, input func, input char_code, input cell_index,
                   output ready);
endinterface

interface tcw_rsp_if;
   import tcw_pkg::*;

   logic             valid;
   logic             ready;
   logic [LOC_W-1:0] cursor_location;
   logic [CELL_W-1:0] cell_data;
   logic             scrolled;

   modport source (output valid, output cursor_location, output cell_data, output scrolled,
                   input ready);
   modport sink   (input valid, input cursor_location, input cell_data, input scrolled,
                   output ready);
endinterface

/* hdl/text_console_writer.sv */
// Text console writer top level: a cursor-driven character cell store.
// Each request word puts a character, clears the screen, reads one cell or, for func 3,
// changes nothing, and returns exactly one response word carrying the cursor location after
// the operation. Requests are taken one at a time. Every cell move goes through the single
// write port of the cell RAM, so a clear or a put that scrolls writes the cells one by one.
// The response sits in an output register, so the next request is taken while a response
// still waits. Cells power up undefined and should be cleared before they are read or
// scrolled. The attribute register resets to 0x0F and may be written only while the block
// is idle.
module text_console_writer #(
   parameter int COLUMNS  = 80,
   parameter int ROWS     = 25,
   parameter int TAB_STOP = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [tcw_pkg::ATTR_W-1:0] csr_wr_data,
   tcw_req_if.sink                    req_port,
   tcw_rsp_if.source                  rsp_port
);
   import tcw_pkg::*;

   tcw_cmd_type    cmd;
   tcw_status_type status;

   tcw_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   tcw_datapath #(
      .COLUMNS  (COLUMNS),
      .ROWS     (ROWS),
      .TAB_STOP (TAB_STOP)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_port    (req_port),
      .rsp_port    (rsp_port),
      .cmd         (cmd),
      .status      (status)
   );
endmodule

/* hdl/tcw_ram.sv */
// Generic single write port RAM with registered read.
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* hdl/tcw_ctrl.sv */
// Sequencer that steps each word through execute, read, scroll, clear and response.
module tcw_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  tcw_pkg::tcw_status_type status,
   output tcw_pkg::tcw_cmd_type    cmd
);
   import tcw_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_EXEC  = 7'b0000010,
      ST_READ  = 7'b0000100,
      ST_COPY  = 7'b0001000,
      ST_BLANK = 7'b0010000,
      ST_CLEAR = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (status.req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            priority if (status.is_put && status.scroll_needed) begin
               state_in = ST_COPY;
            end else if (status.is_clear) begin
               state_in = ST_CLEAR;
            end else if (status.is_read) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            state_in = ST_DONE;
         end
         ST_COPY: begin
            if (status.copy_last) begin
               state_in = ST_BLANK;
            end
         end
         ST_BLANK, ST_CLEAR: begin
            if (status.cell_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd.idle  = (state_ff == ST_IDLE);
      cmd.exec  = (state_ff == ST_EXEC);
      cmd.read  = (state_ff == ST_READ);
      cmd.copy  = (state_ff == ST_COPY);
      cmd.blank = (state_ff == ST_BLANK);
      cmd.clear = (state_ff == ST_CLEAR);
      cmd.done  = (state_ff == ST_DONE);
   end
endmodule

/* hdl/tcw_datapath.sv */
// Cursor, attribute, cell store addressing and response register.
module tcw_datapath #(
   parameter int COLUMNS  = 80,
   parameter int ROWS     = 25,
   parameter int TAB_STOP = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [tcw_pkg::ATTR_W-1:0]  csr_wr_data,
   tcw_req_if.sink                     req_port,
   tcw_rsp_if.source                   rsp_port,
   input  tcw_pkg::tcw_cmd_type        cmd,
   output tcw_pkg::tcw_status_type     status
);
   import tcw_pkg::*;

   localparam int CELL_COUNT   = COLUMNS * ROWS;
   localparam int SCROLL_COUNT = (ROWS - 1) * COLUMNS;
   localparam int MEM_AW       = $clog2(CELL_COUNT);
   localparam int COL_W        = $clog2(COLUMNS);
   localparam int ROW_W        = $clog2(ROWS);
   localparam int CW1          = $clog2(COLUMNS + TAB_STOP + 1);
   localparam int RW1          = $clog2(ROWS + 1);
   localparam int PH_W         = $clog2(TAB_STOP);

   logic [ATTR_W-1:0]  attr_ff;
   logic [COL_W-1:0]   col_ff,   col_in;
   logic [ROW_W-1:0]   row_ff,   row_in;
   logic [PH_W-1:0]    phase_ff, phase_in;

   logic [FUNC_W-1:0]  func_ff;
   logic [CHAR_W-1:0]  char_ff;
   logic [INDEX_W-1:0] idx_ff;
   logic [MEM_AW-1:0]  cnt_ff;
   logic [CELL_W-1:0]  data_ff;
   logic               scrolled_ff;

   logic               rsp_valid_ff;
   logic [LOC_W-1:0]   rsp_loc_ff;
   logic [CELL_W-1:0]  rsp_data_ff;
   logic               rsp_scr_ff;

   logic [CW1-1:0]     col_step;
   logic [RW1-1:0]     row_step;
   logic [PH_W-1:0]    ph_step;
   logic               put_write;
   logic               scroll;
   logic [MEM_AW-1:0]  loc;
   logic               idx_valid;
   logic               load;

   logic               ram_we;
   logic [MEM_AW-1:0]  ram_waddr;
   logic [CELL_W-1:0]  ram_wdata;
   logic               ram_re;
   logic [MEM_AW-1:0]  ram_raddr;
   logic [CELL_W-1:0]  ram_rdata;

   assign loc       = MEM_AW'(row_ff) * MEM_AW'(COLUMNS) + MEM_AW'(col_ff);
   assign idx_valid = (32'(idx_ff) < 32'(CELL_COUNT));
   assign load      = cmd.done && status.rsp_free;

   always_comb begin
      col_step  = CW1'(col_ff);
      row_step  = RW1'(row_ff);
      ph_step   = phase_ff;
      put_write = 1'b0;
      priority if (char_ff == CHAR_BS && col_ff != '0) begin
         col_step = col_step - CW1'(1);
         ph_step  = (phase_ff == '0) ? PH_W'(TAB_STOP - 1) : phase_ff - PH_W'(1);
      end else if (char_ff == CHAR_TAB) begin
         col_step = col_step + CW1'(TAB_STOP) - CW1'(phase_ff);
         ph_step  = '0;
      end else if (char_ff == CHAR_CR) begin
         col_step = '0;
         ph_step  = '0;
      end else if (char_ff == CHAR_LF) begin
         col_step = '0;
         ph_step  = '0;
         row_step = row_step + RW1'(1);
      end else if (char_ff >= CHAR_SPACE && !char_ff[CHAR_W-1]) begin
         put_write = 1'b1;
         col_step  = col_step + CW1'(1);
         ph_step   = (phase_ff == PH_W'(TAB_STOP - 1)) ? '0 : phase_ff + PH_W'(1);
      end else begin
         put_write = 1'b0;
      end
      if (col_step >= CW1'(COLUMNS)) begin
         col_step = '0;
         row_step = row_step + RW1'(1);
         ph_step  = '0;
      end
      scroll = (row_step >= RW1'(ROWS));
   end

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      phase_in = phase_ff;
      if (cmd.exec && status.is_put) begin
         col_in   = COL_W'(col_step);
         row_in   = scroll ? ROW_W'(ROWS - 1) : ROW_W'(row_step);
         phase_in = ph_step;
      end else if (cmd.exec && status.is_clear) begin
         col_in   = '0;
         row_in   = '0;
         phase_in = '0;
      end
   end

   always_comb begin
      status.req_valid     = req_port.valid;
      status.is_put        = (func_ff == FUNC_PUT);
      status.is_clear      = (func_ff == FUNC_CLEAR);
      status.is_read       = (func_ff == FUNC_READ);
      status.scroll_needed = scroll;
      status.copy_last     = (cnt_ff == MEM_AW'(SCROLL_COUNT));
      status.cell_last     = (cnt_ff == MEM_AW'(CELL_COUNT - 1));
      status.rsp_free      = !rsp_valid_ff || rsp_port.ready;
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = cnt_ff;
      ram_wdata = {attr_ff, CHAR_SPACE};
      ram_re    = 1'b0;
      ram_raddr = cnt_ff + MEM_AW'(COLUMNS);
      priority if (cmd.exec) begin
         ram_we    = status.is_put && put_write;
         ram_waddr = loc;
         ram_wdata = {attr_ff, char_ff};
         ram_re    = status.is_read;
         ram_raddr = MEM_AW'(idx_ff);
      end else if (cmd.copy) begin
         ram_re    = !status.copy_last;
         ram_we    = (cnt_ff != '0);
         ram_waddr = cnt_ff - MEM_AW'(1);
         ram_wdata = ram_rdata;
      end else if (cmd.blank || cmd.clear) begin
         ram_we = 1'b1;
      end else begin
         ram_we = 1'b0;
      end
   end

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff      <= ATTR_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            attr_ff <= csr_wr_data;
         end
         col_ff   <= col_in;
         row_ff   <= row_in;
         phase_ff <= phase_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.idle && req_port.valid) begin
         func_ff <= req_port.func;
         char_ff <= req_port.char_code;
         idx_ff  <= req_port.cell_index;
      end
      if (cmd.exec) begin
         cnt_ff      <= '0;
         data_ff     <= '0;
         scrolled_ff <= status.is_put && scroll;
      end else if (cmd.copy) begin
         if (!status.copy_last) begin
            cnt_ff <= cnt_ff + MEM_AW'(1);
         end
      end else if (cmd.blank || cmd.clear) begin
         cnt_ff <= cnt_ff + MEM_AW'(1);
      end
      if (cmd.read) begin
         data_ff <= idx_valid ? ram_rdata : '0;
      end
      if (load) begin
         rsp_loc_ff  <= LOC_W'(loc);
         rsp_data_ff <= data_ff;
         rsp_scr_ff  <= scrolled_ff;
      end
   end

   assign req_port.ready           = cmd.idle;
   assign rsp_port.valid           = rsp_valid_ff;
   assign rsp_port.cursor_location = rsp_loc_ff;
   assign rsp_port.cell_data       = rsp_data_ff;
   assign rsp_port.scrolled        = rsp_scr_ff;

`ifndef ASSERT_OFF
   cursor_in_screen_a: assert property (@(posedge clock) disable iff (reset)
      (CW1'(col_ff) < CW1'(COLUMNS)) && (RW1'(row_ff) < RW1'(ROWS)))
      else $error("cursor outside screen");

   copy_no_overlap_a: assert property (@(posedge clock) disable iff (reset)
      cmd.copy && ram_we && ram_re |-> ram_waddr != ram_raddr)
      else $error("scroll copy writes the cell it reads");

   read_follows_exec_a: assert property (@(posedge clock) disable iff (reset)
      cmd.read |-> $past(cmd.exec) && $past(status.is_read))
      else $error("cell capture without a preceding read");
`endif
endmodule

/* tb/sv/tcw_console_check.sv */
// Checker for the text console writer: watches both channels, predicts and compares each word.
`timescale 1ns / 100ps
module tcw_console_check #(
   parameter int COLUMNS  = 80,
   parameter int ROWS     = 25,
   parameter int TAB_STOP = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [tcw_pkg::ATTR_W-1:0] csr_wr_data,
   tcw_req_if                         req_mon,
   tcw_rsp_if                         rsp_mon,
   output int                         fail_count,
   output int                         pending
);
   import tcw_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam logic [CHAR_W-1:0] CHAR_LAST_PRINTABLE = 8'h7F;

   typedef struct packed {
      logic [LOC_W-1:0]  cursor_location;
      logic [CELL_W-1:0] cell_data;
      logic              scrolled;
   } console_reply_type;

   logic [CELL_W-1:0] screen [CELLS];
   int unsigned       cursor_col = 0;
   int unsigned       cursor_row = 0;
   logic [ATTR_W-1:0] text_attr  = ATTR_RESET;
   console_reply_type awaited_replies [$];
   int                mismatches = 0;
   int                awaiting   = 0;

   assign fail_count = mismatches;
   assign pending    = awaiting;

   task automatic report_mismatch(string what, int got, int want);
      if (mismatches < 50) begin
         $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
      end
      mismatches++;
   endtask

   function automatic console_reply_type run_console_op(logic [FUNC_W-1:0]  func,
                                                        logic [CHAR_W-1:0]  ch,
                                                        logic [INDEX_W-1:0] cell_index);
      console_reply_type reply;
      reply = '0;
      case (func)
         FUNC_PUT: begin
            if (ch == CHAR_BS && cursor_col != 0) begin
               cursor_col--;
            end else if (ch == CHAR_TAB) begin
               cursor_col = cursor_col + TAB_STOP - (cursor_col % TAB_STOP);
            end else if (ch == CHAR_CR) begin
               cursor_col = 0;
            end else if (ch == CHAR_LF) begin
               cursor_col = 0;
               cursor_row++;
            end else if (ch >= CHAR_SPACE && ch <= CHAR_LAST_PRINTABLE) begin
               screen[cursor_row * COLUMNS + cursor_col] = {text_attr, ch};
               cursor_col++;
            end
            if (cursor_col >= COLUMNS) begin
               cursor_col = 0;
               cursor_row++;
            end
            if (cursor_row >= ROWS) begin
               for (int k = 0; k < (ROWS - 1) * COLUMNS; k++) begin
                  screen[k] = screen[k + COLUMNS];
               end
               for (int k = (ROWS - 1) * COLUMNS; k < CELLS; k++) begin
                  screen[k] = {text_attr, CHAR_SPACE};
               end
               cursor_row     = ROWS - 1;
               reply.scrolled = 1'b1;
            end
         end
         FUNC_CLEAR: begin
            for (int k = 0; k < CELLS; k++) begin
               screen[k] = {text_attr, CHAR_SPACE};
            end
            cursor_col = 0;
            cursor_row = 0;
         end
         FUNC_READ: begin
            if (cell_index < CELLS) begin
               reply.cell_data = screen[cell_index];
            end
         end
         default: ;
      endcase
      reply.cursor_location = LOC_W'(cursor_row * COLUMNS + cursor_col);
      return reply;
   endfunction

   always @(posedge clock) begin
      console_reply_type want;
      if (reset) begin
         cursor_col = 0;
         cursor_row = 0;
         text_attr  = ATTR_RESET;
         awaited_replies.delete();
         awaiting   = 0;
      end else begin
         if (csr_wr_en) begin
            text_attr = csr_wr_data;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_replies.size() == 0) begin
               report_mismatch("response word with none awaited", rsp_mon.cursor_location, 0);
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_mon.cursor_location !== want.cursor_location) begin
                  report_mismatch("cursor_location", rsp_mon.cursor_location,
                                  want.cursor_location);
               end
               if (rsp_mon.cell_data !== want.cell_data) begin
                  report_mismatch("cell_data", rsp_mon.cell_data, want.cell_data);
               end
               if (rsp_mon.scrolled !== want.scrolled) begin
                  report_mismatch("scrolled", rsp_mon.scrolled, want.scrolled);
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            awaited_replies.push_back(run_console_op(req_mon.func, req_mon.char_code,
                                                     req_mon.cell_index));
         end
         awaiting = awaited_replies.size();
      end
   end
endmodule

/* tb/sv/tb_text_console_writer.sv */
// Testbench top for the text console writer: clock, reset, stimulus, pacing and verdict.
`timescale 1ns / 100ps
module tb_text_console_writer;
   import tcw_pkg::*;

   typedef enum int {
      PACE_NONE,
      PACE_SEND_IDLE,
      PACE_RECV_STALL,
      PACE_BOTH
   } pace_mode_type;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int     RANDOM_WORDS = 1530;
   localparam int     PHASES       = 8;
   localparam int     LONG_HOLD    = 800;
   localparam longint CYCLE_LIMIT  = 12_000_000;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_wr_en;
   logic [ATTR_W-1:0] csr_wr_data;
   pace_mode_type     pace = PACE_NONE;
   int                hold_requests = 0;
   int                holds_served  = 0;
   int                hold_left     = 0;
   int                fail_count;
   int                pending;
   longint            cycle_count = 0;

   tcw_req_if req_bus ();
   tcw_rsp_if rsp_bus ();

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   text_console_writer dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_port    (req_bus),
      .rsp_port    (rsp_bus)
   );

   tcw_console_check console_check (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= hold_left - 1;
      end else if (hold_requests != holds_served) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= LONG_HOLD;
         holds_served  <= holds_served + 1;
      end else if (pace == PACE_RECV_STALL) begin
         rsp_bus.ready <= ($urandom_range(99) >= 51);
      end else if (pace == PACE_BOTH) begin
         rsp_bus.ready <= ($urandom_range(99) >= 28);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic send_word(logic [FUNC_W-1:0] func, logic [CHAR_W-1:0] ch,
                            logic [INDEX_W-1:0] cell_index);
      int pct;
      pct = (pace == PACE_SEND_IDLE) ? 51 : (pace == PACE_BOTH) ? 28 : 0;
      if ($urandom_range(99) < pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < pct) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.func       <= func;
      req_bus.char_code  <= ch;
      req_bus.cell_index <= cell_index;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic put_char(logic [CHAR_W-1:0] ch);
      send_word(FUNC_PUT, ch, INDEX_W'($urandom));
   endtask

   task automatic read_cell(logic [INDEX_W-1:0] cell_index);
      send_word(FUNC_READ, CHAR_W'($urandom), cell_index);
   endtask

   task automatic send_random_word();
      int roll;
      int pick;
      logic [CHAR_W-1:0] ch;
      roll = $urandom_range(999);
      if (roll < 5) begin
         send_word(FUNC_CLEAR, CHAR_W'($urandom), INDEX_W'($urandom));
      end else if (roll < 15) begin
         send_word(FUNC_UNUSED, CHAR_W'($urandom), INDEX_W'($urandom));
      end else if (roll < 95) begin
         read_cell(($urandom_range(9) == 0) ? INDEX_W'($urandom_range(2047, 2000))
                                            : INDEX_W'($urandom_range(1999)));
      end else begin
         pick = $urandom_range(99);
         if (pick < 6) begin
            ch = CHAR_LF;
         end else if (pick < 9) begin
            ch = CHAR_CR;
         end else if (pick < 14) begin
            ch = CHAR_TAB;
         end else if (pick < 19) begin
            ch = CHAR_BS;
         end else if (pick < 23) begin
            ch = $urandom_range(1) ? CHAR_W'($urandom_range(255, 128))
                                   : CHAR_W'($urandom_range(31));
         end else begin
            ch = CHAR_W'($urandom_range(127, 32));
         end
         put_char(ch);
      end
   endtask

   task automatic write_attribute(logic [ATTR_W-1:0] value);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      logic [ATTR_W-1:0] extremes [4];
      extremes = '{8'hFF, 8'h00, 8'h0F, 8'hFF};

      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.func       <= FUNC_PUT;
      req_bus.char_code  <= '0;
      req_bus.cell_index <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      write_attribute(8'h00);
      send_word(FUNC_CLEAR, 8'hFF, 11'h7FF);
      read_cell(11'd0);
      put_char(8'h41);
      put_char(8'h7F);
      put_char(CHAR_SPACE);
      put_char(8'h1F);
      put_char(8'h80);
      put_char(8'hFF);
      put_char(CHAR_BS);
      read_cell(11'd1);
      put_char(CHAR_CR);
      put_char(CHAR_BS);
      repeat (10) put_char(CHAR_TAB);
      put_char(CHAR_LF);
      read_cell(11'd1999);
      read_cell(11'd2047);
      send_word(FUNC_UNUSED, 8'hFF, 11'h7FF);

      for (int p = 0; p < PHASES; p++) begin
         write_attribute((p % 2) ? ATTR_W'($urandom_range(255)) : extremes[p / 2]);
         pace <= pace_mode_type'(p % 4);
         if (p == 0) begin
            hold_requests <= hold_requests + 1;
         end
         repeat (RANDOM_WORDS / PHASES) send_random_word();
      end

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

/* sim.f */
hdl/tcw_pkg.sv
hdl/tcw_ifs.sv
hdl/tcw_ram.sv
hdl/tcw_ctrl.sv
hdl/tcw_datapath.sv
hdl/text_console_writer.sv
tb/sv/tcw_console_check.sv
tb/sv/tb_text_console_writer.sv
